[hdl/rss_pkg.sv]
package rss_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_LOAD_SPRITE  = 2'd0,
        REQ_LOAD_OVERLAY = 2'd1,
        REQ_TICK         = 2'd2,
        REQ_RENDER       = 2'd3
    } req_code_t;

    localparam int TEXEL_W       = 32;
    localparam int SPRITE_DEPTH  = 1024;
    localparam int OVERLAY_DEPTH = 256;
    localparam int SPRITE_AW     = 10;
    localparam int OVERLAY_AW    = 8;
    localparam int ANGLE_W       = 6;

    localparam logic [ANGLE_W-1:0] ANGLE_RESET   = 6'd2;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 6'd16;
    localparam logic               SPIN_RESET    = 1'b1;
    localparam logic [7:0]         ALPHA_LIMIT   = 8'd128;
    localparam logic [7:0]         ALPHA_OPAQUE  = 8'hFF;

    // Q14 trig, Q14 coordinates, Q28 products
    localparam int TRIG_W  = 16;
    localparam int COORD_W = 19;
    localparam int PROD_W  = TRIG_W + COORD_W;
    localparam int SUM_W   = 36;

    localparam logic signed [SUM_W-1:0] CENTER_Q28  = 36'sh1_0000_0000;   // 16.0
    localparam logic signed [SUM_W-1:0] NEG_ONE_Q28 = -36'sh0_1000_0000;  // -1.0
    localparam logic signed [SUM_W-1:0] EDGE_Q28    = 36'sh2_0000_0000;   // 32.0

    localparam logic signed [TRIG_W-1:0] QUARTER_SINE [17] = '{
        16'sd0,     16'sd1606,  16'sd3196,  16'sd4756,  16'sd6270,  16'sd7723,
        16'sd9102,  16'sd10394, 16'sd11585, 16'sd12665, 16'sd13623, 16'sd14449,
        16'sd15137, 16'sd15679, 16'sd16069, 16'sd16305, 16'sd16384
    };

    // Result of the coordinate transform, handed to the sampler control
    typedef struct packed {
        logic                 in_bounds;
        logic [SPRITE_AW-1:0] sprite_addr;
    } hit_t;

    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [ANGLE_W-1:0] k);
        logic [3:0] q;
        logic [4:0] mirror;
        logic signed [TRIG_W-1:0] v;
        q      = k[3:0];
        mirror = 5'd16 - {1'b0, q};
        case (k[5:4])
            2'd0:    v = QUARTER_SINE[{1'b0, q}];
            2'd1:    v = QUARTER_SINE[mirror];
            2'd2:    v = -QUARTER_SINE[{1'b0, q}];
            2'd3:    v = -QUARTER_SINE[mirror];
            default: v = '0;
        endcase
        return v;
    endfunction

    // (v/15 - 0.5) * 31 in Q14, rounded half away from zero
    function automatic logic signed [COORD_W-1:0] coord_q14(input logic [3:0] v);
        logic signed [COORD_W-1:0] r;
        case (v)
            4'd0:    r = -19'sd253952;
            4'd1:    r = -19'sd220092;
            4'd2:    r = -19'sd186231;
            4'd3:    r = -19'sd152371;
            4'd4:    r = -19'sd118511;
            4'd5:    r = -19'sd84651;
            4'd6:    r = -19'sd50790;
            4'd7:    r = -19'sd16930;
            4'd8:    r = 19'sd16930;
            4'd9:    r = 19'sd50790;
            4'd10:   r = 19'sd84651;
            4'd11:   r = 19'sd118511;
            4'd12:   r = 19'sd152371;
            4'd13:   r = 19'sd186231;
            4'd14:   r = 19'sd220092;
            4'd15:   r = 19'sd253952;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/rss_if.sv]
interface rss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [9:0]  texel_addr;
    logic [31:0] texel_value;
    logic [3:0]  pixel_x;
    logic [3:0]  pixel_y;

    modport source
    (
        output valid, req_type, texel_addr, texel_value, pixel_x, pixel_y,
        input  ready
    );
    modport sink
    (
        input  valid, req_type, texel_addr, texel_value, pixel_x, pixel_y,
        output ready
    );
endinterface

interface rss_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source
    (
        output valid, red, green, blue, alpha,
        input  ready
    );
    modport sink
    (
        input  valid, red, green, blue, alpha,
        output ready
    );
endinterface

interface rss_cfg_if;
    logic valid;
    logic ready;
    logic spin_direction;

    modport source
    (
        output valid, spin_direction,
        input  ready
    );
    modport sink
    (
        input  valid, spin_direction,
        output ready
    );
endinterface

[hdl/rss_ram.sv]
module rss_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rss_xform.sv]
module rss_xform
(
    input  logic                        clk,
    input  logic                        start,
    input  logic [rss_pkg::ANGLE_W-1:0] angle,
    input  logic [3:0]                  pixel_x,
    input  logic [3:0]                  pixel_y,
    output rss_pkg::hit_t               hit
);

    logic signed [rss_pkg::TRIG_W-1:0]  sin_reg, cos_reg;
    logic signed [rss_pkg::COORD_W-1:0] a_reg, b_reg;
    logic signed [rss_pkg::PROD_W-1:0]  ca_reg, sb_reg, cb_reg, sa_reg;
    logic signed [rss_pkg::SUM_W-1:0]   col_q, row_q;
    logic                               col_ok, row_ok;
    logic [4:0]                         col, row;

    // trig and coordinate lookups captured with the request
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sin_reg <= rss_pkg::sine_q14(angle);
            cos_reg <= rss_pkg::sine_q14(rss_pkg::ANGLE_W'(angle + rss_pkg::QUARTER_TURN));
            a_reg   <= rss_pkg::coord_q14(pixel_x);
            b_reg   <= rss_pkg::coord_q14(pixel_y);
        end
    end

    // products, Q28
    always_ff @(posedge clk)
    begin
        ca_reg <= cos_reg * a_reg;
        sb_reg <= sin_reg * b_reg;
        cb_reg <= cos_reg * b_reg;
        sa_reg <= sin_reg * a_reg;
    end

    assign col_q = rss_pkg::SUM_W'(ca_reg) - rss_pkg::SUM_W'(sb_reg) + rss_pkg::CENTER_Q28;
    assign row_q = rss_pkg::SUM_W'(cb_reg) + rss_pkg::SUM_W'(sa_reg) + rss_pkg::CENTER_Q28;

    // truncation toward zero: (-1,0) lands on index 0
    assign col_ok = (col_q > rss_pkg::NEG_ONE_Q28) && (col_q < rss_pkg::EDGE_Q28);
    assign row_ok = (row_q > rss_pkg::NEG_ONE_Q28) && (row_q < rss_pkg::EDGE_Q28);
    assign col    = col_q[rss_pkg::SUM_W-1] ? 5'd0 : col_q[32:28];
    assign row    = row_q[rss_pkg::SUM_W-1] ? 5'd0 : row_q[32:28];

    assign hit.in_bounds   = col_ok && row_ok;
    assign hit.sprite_addr = {row, col};

endmodule

[hdl/rotated_sprite_sampler.sv]
// Rotated sprite sampler. Holds a 32x32 ARGB sprite and a 16x16 ARGB overlay in
// two on-chip RAMs plus a 6-bit angle (64 steps per turn, reset 2). Request beats
// on req: load sprite texel, load overlay texel (addresses above 255 dropped),
// tick (angle +1 when spin_direction is 1, -1 when 0), render pixel (x,y).
// Loads and ticks produce no output beat; back-to-back loads and ticks are taken
// every cycle while no render is in flight. A render maps the pixel to sprite
// space, rotates it about the sprite center, samples nearest neighbor and returns
// one pixel beat. The beat is registered after the trig/coord lookup, multiply
// and sum+bounds with RAM read stages; req opens again in the same cycle the beat
// is raised, so a new render is taken only after the previous one has left.
// req is not ready while a render is in flight, and a finished render holds in
// flight while the previous pixel waits on a stalled output.
// Out-of-bounds pixels return all zeros; an overlay texel with alpha above 128
// overrides the sprite texel. Alpha out is 255 or 0. The RAMs have no reset:
// sampling a texel never loaded returns undefined data. cfg writes are taken
// at any time, but are meant to change only while the block is idle.
module rotated_sprite_sampler
(
    input  logic   clk,
    input  logic   rst_n,
    rss_req_if.sink   req,
    rss_pix_if.source pix,
    rss_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_READ
    } state_t;

    state_t                        state_reg, state_next;
    logic [rss_pkg::ANGLE_W-1:0]   angle_reg, angle_next;
    logic                          spin_reg, spin_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rss_pkg::TEXEL_W-1:0]   color_reg, color_next;

    logic [3:0]                    px_reg, py_reg;
    logic                          in_bounds_reg;

    logic                          req_fire;
    logic                          sprite_we, overlay_we, mem_re;
    logic [rss_pkg::TEXEL_W-1:0]   sprite_rdata, overlay_rdata;
    logic [rss_pkg::TEXEL_W-1:0]   picked;
    rss_pkg::hit_t                 hit;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    assign sprite_we  = req_fire && (req.req_type == rss_pkg::REQ_LOAD_SPRITE);
    assign overlay_we = req_fire && (req.req_type == rss_pkg::REQ_LOAD_OVERLAY)
                        && (req.texel_addr[rss_pkg::SPRITE_AW-1:rss_pkg::OVERLAY_AW] == '0);
    // both RAMs are read once per render, in the sum stage
    assign mem_re     = (state_reg == S_SUM);

    rss_ram
    #(
        .WIDTH (rss_pkg::TEXEL_W),
        .DEPTH (rss_pkg::SPRITE_DEPTH)
    )
    u_sprite_ram
    (
        .clk   (clk),
        .we    (sprite_we),
        .waddr (req.texel_addr),
        .wdata (req.texel_value),
        .re    (mem_re),
        .raddr (hit.sprite_addr),
        .rdata (sprite_rdata)
    );

    rss_ram
    #(
        .WIDTH (rss_pkg::TEXEL_W),
        .DEPTH (rss_pkg::OVERLAY_DEPTH)
    )
    u_overlay_ram
    (
        .clk   (clk),
        .we    (overlay_we),
        .waddr (req.texel_addr[rss_pkg::OVERLAY_AW-1:0]),
        .wdata (req.texel_value),
        .re    (mem_re),
        .raddr ({py_reg, px_reg}),
        .rdata (overlay_rdata)
    );

    rss_xform u_xform
    (
        .clk     (clk),
        .start   (req_fire),
        .angle   (angle_reg),
        .pixel_x (req.pixel_x),
        .pixel_y (req.pixel_y),
        .hit     (hit)
    );

    // pixel coordinates and bounds flag ride along with the render
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            px_reg <= req.pixel_x;
            py_reg <= req.pixel_y;
        end
        if (mem_re)
        begin
            in_bounds_reg <= hit.in_bounds;
        end
    end

    // overlay wins when its alpha is above 128; outside the sprite, black
    always_comb
    begin
        if (!in_bounds_reg)
        begin
            picked = '0;
        end
        else if (overlay_rdata[31:24] > rss_pkg::ALPHA_LIMIT)
        begin
            picked = overlay_rdata;
        end
        else
        begin
            picked = sprite_rdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        angle_next     = angle_reg;
        spin_next      = spin_reg;
        out_valid_next = out_valid_reg && !pix.ready;
        color_next     = color_reg;

        if (cfg.valid && cfg.ready)
        begin
            spin_next = cfg.spin_direction;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == rss_pkg::REQ_TICK))
                begin
                    angle_next = spin_reg ? rss_pkg::ANGLE_W'(angle_reg + 6'd1)
                                          : rss_pkg::ANGLE_W'(angle_reg - 6'd1);
                end
                if (req_fire && (req.req_type == rss_pkg::REQ_RENDER))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                // hold the RAM data until the output register frees up
                if (!out_valid_reg || pix.ready)
                begin
                    out_valid_next = 1'b1;
                    color_next     = picked;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            angle_reg     <= rss_pkg::ANGLE_RESET;
            spin_reg      <= rss_pkg::SPIN_RESET;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            angle_reg     <= angle_next;
            spin_reg      <= spin_next;
            out_valid_reg <= out_valid_next;
            color_reg     <= color_next;
        end
    end

    assign pix.valid = out_valid_reg;
    assign pix.red   = color_reg[23:16];
    assign pix.green = color_reg[15:8];
    assign pix.blue  = color_reg[7:0];
    assign pix.alpha = (color_reg[31:24] > rss_pkg::ALPHA_LIMIT) ? rss_pkg::ALPHA_OPAQUE : 8'd0;

`ifndef SYNTHESIS
    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == rss_pkg::REQ_RENDER)) |=> (state_reg == S_MUL))
        else $error("render accept did not start the pipeline");

    a_tick_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == rss_pkg::REQ_TICK) && spin_reg)
        |=> (angle_reg == rss_pkg::ANGLE_W'($past(angle_reg) + 6'd1)))
        else $error("forward tick did not advance angle");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_READ))
        else $error("output beat raised outside result stage");

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!sprite_we && !overlay_we))
        else $error("texel load overlapped a render read");

    a_angle_static_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(angle_reg))
        else $error("angle changed during a render");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    // One request beat as the driver puts it on the wire
    typedef struct {
        rss_pkg::req_code_t kind;
        logic [9:0]  addr;
        logic [31:0] value;
        logic [3:0]  px;
        logic [3:0]  py;
    } req_beat_t;

    // One rendered pixel as it leaves the block
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam real        PI             = 3.14159265358979323846;
    localparam logic [5:0] ANGLE_AT_RESET = 6'd2;
    localparam logic       SPIN_AT_RESET  = 1'b1;
    localparam int         SETTLE_CYCLES  = 8;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    rss_req_if req();
    rss_pix_if pix();
    rss_cfg_if cfg();

    rotated_sprite_sampler u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pix   (pix),
        .cfg   (cfg)
    );

    // Stimulus waiting for the driver, and pixels the block still owes us
    req_beat_t request_backlog [$];
    pixel_t    pending_pixels [$];
    int        n_errors = 0;
    int        n_beats  = 0;
    logic      calm     = 1'b0;   // window with no idling on either side

    // Shadow of what has been loaded so far, kept by the stimulus side so a
    // render never samples a texel that was never written.
    bit         sprite_loaded  [rss_pkg::SPRITE_DEPTH];
    bit         overlay_loaded [rss_pkg::OVERLAY_DEPTH];
    logic [5:0] plan_angle = ANGLE_AT_RESET;
    logic       plan_spin  = SPIN_AT_RESET;

    // Predictor's own copy of the block state
    logic [31:0] sprite_mem  [rss_pkg::SPRITE_DEPTH];
    logic [31:0] overlay_mem [rss_pkg::OVERLAY_DEPTH];
    logic [5:0]  angle_now;
    logic        spin_now;

    //------------------------------------------------------------------
    // Fixed-point geometry
    //------------------------------------------------------------------

    // sin(2*pi*k/64) in Q14, rounded half away from zero
    function automatic longint trig_q14(input int k);
        real r;
        r = 16384.0 * $sin(2.0 * PI * (k % 64) / 64.0);
        return (r < 0.0) ? -longint'($rtoi(-r + 0.5)) : longint'($rtoi(r + 0.5));
    endfunction

    // (v/15 - 0.5) * 31 in Q14, rounded half away from zero
    function automatic longint coord_q14(input logic [3:0] v);
        longint n;
        n = (62 * longint'(v) - 465) * 16384;
        return (n >= 0) ? (n + 15) / 30 : -((-n + 15) / 30);
    endfunction

    // Output pixel -> sprite texel. Products summed exactly in Q28, then the
    // 16.0 offset, then truncation toward zero (so -0.x lands on index 0).
    function automatic void map_pixel(input logic [5:0] ang, input logic [3:0] px,
                                      input logic [3:0] py, output bit hit,
                                      output logic [9:0] spot);
        longint s, c, a, b, col, row, one;
        one = longint'(1) << 28;
        s   = trig_q14(int'(ang));
        c   = trig_q14(int'(ang) + 16);
        a   = coord_q14(px);
        b   = coord_q14(py);
        col = (c * a - s * b + 16 * one) / one;
        row = (c * b + s * a + 16 * one) / one;
        hit  = (col >= 0) && (col < 32) && (row >= 0) && (row < 32);
        spot = hit ? 10'(col + row * 32) : 10'd0;
    endfunction

    function automatic pixel_t render_pixel(input logic [3:0] px, input logic [3:0] py);
        bit          hit;
        logic [9:0]  spot;
        logic [31:0] over;
        logic [31:0] color;
        pixel_t      p;
        map_pixel(angle_now, px, py, hit, spot);
        color = '0;     // out of bounds: transparent black
        if (hit)
        begin
            over  = overlay_mem[{py, px}];
            color = sprite_mem[spot];
            if (over[31:24] > 8'd128)
                color = over;   // opaque overlay wins
        end
        p.red   = color[23:16];
        p.green = color[15:8];
        p.blue  = color[7:0];
        p.alpha = (color[31:24] > 8'd128) ? 8'hFF : 8'h00;
        return p;
    endfunction

    //------------------------------------------------------------------
    // Request driver: pops the backlog, idles about 22% of the time
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        req_beat_t nxt;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.req_type    <= '0;
            req.texel_addr  <= '0;
            req.texel_value <= '0;
            req.pixel_x     <= '0;
            req.pixel_y     <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= 22))
            begin
                nxt = request_backlog.pop_front();
                req.valid       <= 1'b1;
                req.req_type    <= nxt.kind;
                req.texel_addr  <= nxt.addr;
                req.texel_value <= nxt.value;
                req.pixel_x     <= nxt.px;
                req.pixel_y     <= nxt.py;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------
    // Predictor and pixel checker. Request beats are handled before pixel
    // beats so an expectation is always queued ahead of its check.
    //------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            angle_now = ANGLE_AT_RESET;
            spin_now  = SPIN_AT_RESET;
            pix.ready <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                spin_now = cfg.spin_direction;

            if (req.valid && req.ready)
            begin
                n_beats++;
                case (req.req_type)
                    rss_pkg::REQ_LOAD_SPRITE:
                        sprite_mem[req.texel_addr] = req.texel_value;
                    rss_pkg::REQ_LOAD_OVERLAY:
                        if (req.texel_addr < rss_pkg::OVERLAY_DEPTH)   // high addresses dropped
                            overlay_mem[req.texel_addr[7:0]] = req.texel_value;
                    rss_pkg::REQ_TICK:
                        angle_now = spin_now ? angle_now + 6'd1 : angle_now - 6'd1;
                    rss_pkg::REQ_RENDER:
                        pending_pixels.push_back(render_pixel(req.pixel_x, req.pixel_y));
                    default: ;
                endcase
            end

            if (pix.valid && pix.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel beat, expected none, actual %02h %02h %02h %02h",
                             $time, pix.red, pix.green, pix.blue, pix.alpha);
                    n_errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("red",   want.red,   pix.red);
                    check_field("green", want.green, pix.green);
                    check_field("blue",  want.blue,  pix.blue);
                    check_field("alpha", want.alpha, pix.alpha);
                end
            end

            calm      <= (n_beats >= 700) && (n_beats < 1000);
            pix.ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    //------------------------------------------------------------------
    // Stimulus building
    //------------------------------------------------------------------

    // Mostly random, with alpha often right at the 128/129 threshold
    function automatic logic [31:0] random_texel();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(5))
            0:       v[31:24] = 8'd128;
            1:       v[31:24] = 8'd129;
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_beat(input rss_pkg::req_code_t kind, input logic [9:0] addr,
                              input logic [31:0] value, input logic [3:0] px,
                              input logic [3:0] py);
        req_beat_t b;
        b.kind  = kind;
        b.addr  = addr;
        b.value = value;
        b.px    = px;
        b.py    = py;
        request_backlog.push_back(b);
        case (kind)
            rss_pkg::REQ_LOAD_SPRITE:
                sprite_loaded[addr] = 1'b1;
            rss_pkg::REQ_LOAD_OVERLAY:
                if (addr < rss_pkg::OVERLAY_DEPTH)
                    overlay_loaded[addr[7:0]] = 1'b1;
            rss_pkg::REQ_TICK:
                plan_angle = plan_spin ? plan_angle + 6'd1 : plan_angle - 6'd1;
            default: ;
        endcase
    endtask

    // Render, preceded by loads of whatever texels it would touch unwritten
    task automatic queue_render(input logic [3:0] px, input logic [3:0] py);
        bit         hit;
        logic [9:0] spot;
        logic [7:0] ov_idx;
        ov_idx = {py, px};
        map_pixel(plan_angle, px, py, hit, spot);
        if (hit && !sprite_loaded[spot])
            queue_beat(rss_pkg::REQ_LOAD_SPRITE, spot, random_texel(),
                       4'($urandom), 4'($urandom));
        if (hit && !overlay_loaded[ov_idx])
            queue_beat(rss_pkg::REQ_LOAD_OVERLAY, {2'b00, ov_idx}, random_texel(),
                       4'($urandom), 4'($urandom));
        queue_beat(rss_pkg::REQ_RENDER, 10'($urandom), $urandom, px, py);
    endtask

    task automatic queue_mixed_traffic(input int n);
        int r;
        logic [9:0] a;
        repeat (n)
        begin
            r = int'($urandom_range(99));
            if (r < 35)
                queue_render(4'($urandom), 4'($urandom));
            else if (r < 60)
                queue_beat(rss_pkg::REQ_LOAD_SPRITE, 10'($urandom), random_texel(),
                           4'($urandom), 4'($urandom));
            else if (r < 75)
            begin
                // occasional out-of-range overlay address
                a = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(255));
                queue_beat(rss_pkg::REQ_LOAD_OVERLAY, a, random_texel(),
                           4'($urandom), 4'($urandom));
            end
            else
                queue_beat(rss_pkg::REQ_TICK, 10'($urandom), $urandom,
                           4'($urandom), 4'($urandom));
        end
    endtask

    // Sender holds off until every pixel is back and the pipe has settled
    task automatic wait_quiet();
        @(negedge clk);
        while (request_backlog.size() != 0 || req.valid || pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_spin(input logic dir);
        @(posedge clk);
        cfg.valid          <= 1'b1;
        cfg.spin_direction <= dir;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        plan_spin = dir;
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        bit         hit;
        logic [9:0] center;

        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.req_type       = '0;
        req.texel_addr     = '0;
        req.texel_value    = '0;
        req.pixel_x        = '0;
        req.pixel_y        = '0;
        pix.ready          = 1'b0;
        cfg.valid          = 1'b0;
        cfg.spin_direction = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: address/data extremes, ignored overlay addresses
        queue_beat(rss_pkg::REQ_LOAD_SPRITE,  10'd0,    32'hFFFF_FFFF, 4'd0,  4'd0);
        queue_beat(rss_pkg::REQ_LOAD_SPRITE,  10'd1023, 32'h0000_0000, 4'd15, 4'd15);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd0,    32'hFFFF_FFFF, 4'd15, 4'd0);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd255,  32'h0000_0000, 4'd0,  4'd15);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd256,  32'h1234_5678, 4'd0,  4'd0);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd1023, 32'hFEDC_BA98, 4'd0,  4'd0);

        // Center pixel sits inside the sprite at the reset angle
        map_pixel(plan_angle, 4'd7, 4'd7, hit, center);
        // sprite opaque, overlay at 128 does not override
        queue_beat(rss_pkg::REQ_LOAD_SPRITE,  center,  32'h81A1_B2C3, 4'd0, 4'd0);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd119, 32'h800F_0E0D, 4'd0, 4'd0);
        queue_render(4'd7, 4'd7);
        // overlay at 129 overrides
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd119, 32'h8110_2030, 4'd0, 4'd0);
        queue_render(4'd7, 4'd7);
        // low alpha keeps RGB, alpha out 0
        queue_beat(rss_pkg::REQ_LOAD_SPRITE,  center,  32'h8044_5566, 4'd0, 4'd0);
        queue_beat(rss_pkg::REQ_LOAD_OVERLAY, 10'd119, 32'h0077_8899, 4'd0, 4'd0);
        queue_render(4'd7, 4'd7);

        // Corners (mostly outside the sprite), then a couple of ticks
        queue_render(4'd0,  4'd0);
        queue_render(4'd15, 4'd15);
        queue_render(4'd0,  4'd15);
        queue_render(4'd15, 4'd0);
        queue_beat(rss_pkg::REQ_TICK, 10'd0, 32'd0, 4'd0, 4'd0);
        queue_beat(rss_pkg::REQ_TICK, 10'd1023, 32'hFFFF_FFFF, 4'd15, 4'd15);
        queue_render(4'd8, 4'd8);
        queue_render(4'd15, 4'd0);
        wait_quiet();

        // Random traffic under both spin directions
        write_spin(1'b0);
        queue_mixed_traffic(320);
        wait_quiet();

        write_spin(1'b1);
        queue_mixed_traffic(320);
        wait_quiet();

        write_spin(1'b0);
        queue_mixed_traffic(280);
        wait_quiet();

        write_spin(1'b1);
        queue_mixed_traffic(300);
        wait_quiet();

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
